@@ rtl/frvr_pkg.sv @@
// Shared widths, constants and inter-module structs for the frame interval repeat voter.
// Used by the table, the divider, the top level and the testbench; it depends on nothing else.
`default_nettype none

package frvr_pkg;

   // Field and state widths.
   localparam int STAMP_W = 64;
   localparam int IVAL_W  = 63;
   localparam int COUNT_W = 16;
   localparam int AGE_W   = 4;
   localparam int STEP_W  = 6;

   // Saturation value of the repeat count and the refresh period of the reference.
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
   localparam logic [COUNT_W-1:0] COUNT_ONE     = 16'd1;
   localparam logic [AGE_W-1:0]   REFRESH_LIMIT = 4'd8;

   // Request to the rounding divider.
   typedef struct packed {
      logic              start;
      logic [IVAL_W-1:0] dividend;
      logic [IVAL_W-1:0] divisor;
   } div_req_type;

   // Answer of the rounding divider.
   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] count;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/frvr_table.sv @@
// Interval table RAM: one write port and one read port with registered read data.
// Depends on frvr_pkg for the entry width.
`default_nettype none

module frvr_table #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [frvr_pkg::IVAL_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output      logic [frvr_pkg::IVAL_W-1:0] rd_data
);
   import frvr_pkg::*;

   logic [IVAL_W-1:0] mem [DEPTH];
   logic [IVAL_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/frvr_div.sv @@
// Bit-serial restoring divider that rounds half up and saturates to the count width.
// Depends on frvr_pkg for widths and the request and answer structs.
`default_nettype none

module frvr_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire frvr_pkg::div_req_type div_req,
   output      frvr_pkg::div_rsp_type div_rsp
);
   import frvr_pkg::*;

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_ROUND
   } div_state_type;

   div_state_type        state_ff, state_in;
   logic [IVAL_W-1:0]    num_ff, num_in;
   logic [IVAL_W-1:0]    rem_ff, rem_in;
   logic [IVAL_W-1:0]    dvs_ff, dvs_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 done_ff, done_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [IVAL_W:0]      shifted;
   logic [IVAL_W+1:0]    trial;
   logic                 round_up;
   logic                 high_bits;

   // One quotient bit per cycle; the quotient shifts into the dividend register.
   assign shifted   = {rem_ff, num_ff[IVAL_W-1]};
   assign trial     = {1'b0, shifted} - {2'b00, dvs_ff};
   assign round_up  = {rem_ff, 1'b0} >= {1'b0, dvs_ff};
   assign high_bits = |num_ff[IVAL_W-1:COUNT_W];

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               num_in   = div_req.dividend;
               dvs_in   = div_req.divisor;
               rem_in   = '0;
               step_in  = STEP_W'(IVAL_W - 1);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (!trial[IVAL_W+1]) begin
               rem_in = trial[IVAL_W-1:0];
               num_in = {num_ff[IVAL_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[IVAL_W-1:0];
               num_in = {num_ff[IVAL_W-2:0], 1'b0};
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = D_ROUND;
            end
         end
         D_ROUND: begin
            // Round half up, then clamp to the largest count.
            if (high_bits || (num_ff[COUNT_W-1:0] == COUNT_MAX)) begin
               count_in = COUNT_MAX;
            end else begin
               count_in = num_ff[COUNT_W-1:0] + COUNT_W'(round_up);
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         dvs_ff   <= dvs_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.count = count_ff;

endmodule

`default_nettype wire

@@ rtl/frame_interval_repeat_voter.sv @@
// Top level of the frame interval repeat voter: sequencer, interval table and divider.
// Depends on frvr_pkg, frvr_table and frvr_div.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_pts_value   (64 bits, signed)
//   rsp      out        rsp_valid/rsp_ready   rsp_repeat_count (16 bits, unsigned)
//
// A zero, negative or non-increasing timestamp goes from the idle state straight to the finish
// state, and the next beat is taken once the output register has taken its count.
// Any other timestamp steps through the read, diff and test states for each table entry, then
// the update state, the divide state unless the reference is zero, and the finish state; the
// next beat is taken only back in idle: the table is scanned through the single RAM read port,
// and the divider retires one quotient bit per cycle over the 63 bits of the interval.
// Reset is synchronous; the table RAM needs no clearing pass since the fill count guards it.
// A finished beat waits in the output register while the next beat is accepted; a second
// finished beat holds the sequencer, and with it req_ready, until rsp_ready frees the register.
`default_nettype none

module frame_interval_repeat_voter #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic signed [frvr_pkg::STAMP_W-1:0]  req_pts_value,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic [frvr_pkg::COUNT_W-1:0]         rsp_repeat_count
);
   import frvr_pkg::*;

   localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIFF,
      ST_TEST,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [IVAL_W-1:0]   prev_ff, prev_in;
   logic [IVAL_W-1:0]   ref_ff, ref_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [AGE_W-1:0]    age_ff, age_in;
   logic [IVAL_W-1:0]   d_ff, d_in;
   logic [IVAL_W-1:0]   k_ff, k_in;
   logic [IVAL_W-1:0]   diff_ff, diff_in;
   logic [IVAL_W-1:0]   min_ff, min_in;
   logic [IVAL_W-1:0]   w_ff, w_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                found_ff, found_in;
   logic                start_ff, start_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                rd_en;
   logic [IVAL_W-1:0]   rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [IVAL_W+2:0]   five_diff;
   logic [IVAL_W+2:0]   twice_k;
   logic                close;
   logic                last_entry;
   logic                insert;
   logic [IVAL_W-1:0]   min_new;
   logic [AGE_W-1:0]    age_next;
   logic                refresh;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   // Interval table.
   frvr_table #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (d_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Rounding divider for interval over reference.
   assign div_req.start    = start_ff;
   assign div_req.dividend = d_ff;
   assign div_req.divisor  = w_ff;

   frvr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Tolerance test 5*|d-k| < 2*k, exact in 66 bits.
   assign five_diff  = {1'b0, diff_ff, 2'b00} + {3'b000, diff_ff};
   assign twice_k    = {2'b00, k_ff, 1'b0};
   assign close      = five_diff < twice_k;
   assign last_entry = (FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff;

   // Table insertion and reference refresh.
   assign insert   = !found_ff && (fill_ff < FILL_W'(TABLE_ENTRIES));
   assign min_new  = (insert && (d_ff < min_ff)) ? d_ff : min_ff;
   assign age_next = age_ff + AGE_W'(1);
   assign refresh  = (age_next > REFRESH_LIMIT) || (ref_ff == '0);
   assign wr_addr  = fill_ff[IDX_W-1:0];

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      ref_in       = ref_ff;
      fill_in      = fill_ff;
      age_in       = age_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      diff_in      = diff_ff;
      min_in       = min_ff;
      w_in         = w_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      start_in     = 1'b0;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ((req_pts_value == '0) || req_pts_value[STAMP_W-1]) begin
                  count_in = COUNT_ONE;
                  state_in = ST_FINISH;
               end else if (req_pts_value[IVAL_W-1:0] <= prev_ff) begin
                  prev_in  = req_pts_value[IVAL_W-1:0];
                  count_in = COUNT_ONE;
                  state_in = ST_FINISH;
               end else begin
                  d_in     = req_pts_value[IVAL_W-1:0] - prev_ff;
                  prev_in  = req_pts_value[IVAL_W-1:0];
                  found_in = 1'b0;
                  min_in   = '1;
                  idx_in   = '0;
                  state_in = (fill_ff == '0) ? ST_UPDATE : ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Entry arrives from the RAM: distance to the interval and running minimum.
            k_in    = rd_data;
            diff_in = (d_ff > rd_data) ? (d_ff - rd_data) : (rd_data - d_ff);
            if (rd_data < min_ff) begin
               min_in = rd_data;
            end
            state_in = ST_TEST;
         end
         ST_TEST: begin
            found_in = found_ff | close;
            idx_in   = idx_ff + IDX_W'(1);
            state_in = last_entry ? ST_UPDATE : ST_READ;
         end
         ST_UPDATE: begin
            wr_en = insert;
            if (insert) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (refresh) begin
               age_in = '0;
               ref_in = min_new;
               w_in   = min_new;
            end else begin
               age_in = age_next;
               w_in   = ref_ff;
            end
            if (w_in == '0) begin
               count_in = COUNT_ONE;
               state_in = ST_FINISH;
            end else begin
               start_in = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               count_in = div_rsp.count;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hand the count to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         ref_ff       <= '0;
         fill_ff      <= '0;
         age_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         ref_ff       <= ref_in;
         fill_ff      <= fill_in;
         age_ff       <= age_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
         k_ff         <= k_in;
         diff_ff      <= diff_in;
         min_ff       <= min_in;
         w_ff         <= w_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_repeat_count = rsp_count_ff;

   // The table never holds more entries than it has room for.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TABLE_ENTRIES))
      else $error("table fill exceeds table depth");

   // The refresh counter wraps before it passes the refresh period.
   a_age_bound: assert property (@(posedge clock) disable iff (reset)
      age_ff <= REFRESH_LIMIT)
      else $error("refresh age beyond its period");

   // A reference is set exactly when the table holds an entry.
   a_ref_with_table: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) == (ref_ff == '0))
      else $error("reference and table fill disagree");

   // The divider is never started with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (w_ff != '0))
      else $error("divider started with zero reference");

endmodule

`default_nettype wire

@@ tb/sv/frame_interval_repeat_voter_tb.sv @@
// Self-checking testbench for frame_interval_repeat_voter: random handshakes on both channels,
// with each repeat count checked against an in-bench model of the interval table and reference.
// Depends on frvr_pkg and the RTL of frame_interval_repeat_voter.
`timescale 1ns / 1ps

module frame_interval_repeat_voter_tb;
   import frvr_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int TABLE_ENTRIES  = 16;
   localparam int TOTAL_STAMPS   = 1050;
   localparam int LONG_HOLD_AT   = 300;
   localparam int LONG_HOLD_LEN  = 500;
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [STAMP_W-1:0] stamp;
      bit                 wait_idle;
   } stamp_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [STAMP_W-1:0]   req_pts_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COUNT_W-1:0]   rsp_repeat_count;

   // Stimulus and scoreboard storage.
   stamp_beat_type       pending_stamps[$];
   logic [COUNT_W-1:0]   expected_counts[$];
   int                   stamps_queued = 0;
   int                   stamps_accepted = 0;
   int                   error_count = 0;

   // Generator state: the last positive stamp queued, and a request to pause the sender.
   logic [STAMP_W-1:0]   gen_stamp = '0;
   bit                   drain_next = 1'b0;

   // Model state of the voter.
   logic [STAMP_W-1:0]   last_stamp = '0;
   logic [IVAL_W-1:0]    ref_interval = '0;
   logic [IVAL_W-1:0]    interval_table[TABLE_ENTRIES];
   int                   table_fill = 0;
   int                   refresh_age = 0;

   frame_interval_repeat_voter #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pts_value   (req_pts_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_repeat_count(rsp_repeat_count)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic logic [STAMP_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Updates the model with one stamp and returns the repeat count it yields.
   function automatic logic [COUNT_W-1:0] vote_repeat_count(input logic [STAMP_W-1:0] stamp);
      logic [IVAL_W-1:0] interval;
      logic [IVAL_W-1:0] diff;
      logic [IVAL_W-1:0] table_min;
      logic [IVAL_W+2:0] five_diff;
      logic [IVAL_W+2:0] twice_entry;
      logic [STAMP_W-1:0] quotient;
      logic [STAMP_W-1:0] remainder;
      bit matched;
      matched = 1'b0;
      if (stamp == '0 || stamp[STAMP_W-1])
         return COUNT_ONE;
      if (stamp <= last_stamp) begin
         last_stamp = stamp;
         return COUNT_ONE;
      end
      interval = IVAL_W'(stamp - last_stamp);
      last_stamp = stamp;

      // An interval within 40 percent of an entry is already represented.
      for (int i = 0; i < table_fill; i++) begin
         diff = (interval > interval_table[i]) ? interval - interval_table[i]
                                               : interval_table[i] - interval;
         five_diff = (IVAL_W+3)'(diff) * 5;
         twice_entry = {2'b00, interval_table[i], 1'b0};
         if (five_diff < twice_entry)
            matched = 1'b1;
      end
      if (!matched && table_fill < TABLE_ENTRIES) begin
         interval_table[table_fill] = interval;
         table_fill++;
      end

      // The reference follows the table minimum, refreshed on first use and every ninth interval.
      refresh_age++;
      if (refresh_age > REFRESH_LIMIT || ref_interval == '0) begin
         refresh_age = 0;
         table_min = '0;
         for (int i = 0; i < table_fill; i++)
            if (i == 0 || interval_table[i] < table_min)
               table_min = interval_table[i];
         ref_interval = table_min;
      end
      if (ref_interval == '0)
         return COUNT_ONE;

      // Round half up, then saturate.
      quotient = STAMP_W'(interval) / STAMP_W'(ref_interval);
      remainder = STAMP_W'(interval) % STAMP_W'(ref_interval);
      if ((remainder << 1) >= STAMP_W'(ref_interval))
         quotient++;
      return (quotient > STAMP_W'(COUNT_MAX)) ? COUNT_MAX : quotient[COUNT_W-1:0];
   endfunction

   task automatic push_stamp(input logic [STAMP_W-1:0] stamp);
      stamp_beat_type beat;
      beat.stamp = stamp;
      beat.wait_idle = drain_next;
      drain_next = 1'b0;
      pending_stamps.insert(pending_stamps.size(), beat);
      stamps_queued++;
      if (stamp != '0 && !stamp[STAMP_W-1])
         gen_stamp = stamp;
   endtask

   // Queues the stamp one interval on; a sum that would turn negative restarts low.
   task automatic push_interval(input logic [STAMP_W-1:0] interval);
      logic [STAMP_W-1:0] next_stamp;
      next_stamp = gen_stamp + interval;
      if (next_stamp[STAMP_W-1])
         push_stamp(interval);
      else
         push_stamp(next_stamp);
   endtask

   // Sender: presents queued stamps with random gaps and predicts each accepted beat.
   bit sender_burst = 1'b0;
   int send_gap = 0;

   always @(posedge clock) begin
      stamp_beat_type beat;
      logic [COUNT_W-1:0] predicted;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted = vote_repeat_count(req_pts_value);
            expected_counts.insert(expected_counts.size(), predicted);
            stamps_accepted++;
         end
         if (req_valid && !req_ready) begin
            // The offered beat stays on the bus until it is taken.
         end else if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_stamps.size() != 0 &&
                      (!pending_stamps[0].wait_idle || expected_counts.size() == 0)) begin
            beat = pending_stamps.pop_front();
            req_pts_value <= beat.stamp;
            req_valid <= 1'b1;
            if ($urandom_range(0, 29) == 0)
               sender_burst = !sender_burst;
            send_gap = sender_burst ? 0 : $urandom_range(0, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver ready: a random hold after each beat, and one long hold to back up the block.
   bit receiver_burst = 1'b0;
   int ready_hold = 0;
   int rsp_beats = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if ($urandom_range(0, 39) == 0)
               receiver_burst = !receiver_burst;
            if (rsp_beats == LONG_HOLD_AT)
               ready_hold = LONG_HOLD_LEN;
            else
               ready_hold = receiver_burst ? 0 : $urandom_range(0, 15);
         end else if (ready_hold != 0) begin
            ready_hold--;
         end
         rsp_ready <= (ready_hold == 0);
      end
   end

   // Result checker: each accepted beat is compared with the oldest prediction.
   always @(posedge clock) begin
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_counts.size() == 0) begin
            $error("repeat_count: unexpected beat, actual %0d", rsp_repeat_count);
            error_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_repeat_count !== want) begin
               $error("repeat_count mismatch: expected %0d, actual %0d", want, rsp_repeat_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [STAMP_W-1:0] rnd;
      logic [STAMP_W-1:0] base;
      logic [STAMP_W-1:0] interval;
      int exponent;
      int run_len;
      int pick;

      // Directed part: non-positive stamps, the widest interval, non-increasing stamps,
      // a stale reference giving zero, refresh on the ninth interval, rounding and saturation.
      push_stamp('0);
      push_stamp(64'h8000_0000_0000_0000);
      push_stamp(64'hFFFF_FFFF_FFFF_FFFF);
      push_stamp(64'h7FFF_FFFF_FFFF_FFFF);
      push_stamp(64'd5);
      push_stamp(64'd5);
      push_stamp(64'd1);
      push_interval(64'd1000);
      push_interval(64'd1000);
      push_interval(64'd1400);
      push_interval(64'd599);
      push_interval(64'd600);
      push_interval(64'd1500);
      push_interval(64'd1 << 40);
      push_interval(64'd3000);
      push_interval(64'd1000);
      push_interval(64'd1 << 40);
      push_interval(64'd898);
      push_interval(64'd899);

      // Random part: mostly runs of related intervals, some noise, some sender pauses.
      drain_next = 1'b1;
      while (stamps_queued < TOTAL_STAMPS) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            rnd = rand64();
            case ($urandom_range(0, 3))
               0: push_stamp(rnd);
               1: push_stamp('0);
               2: push_stamp(gen_stamp >> $urandom_range(1, 8));
               default: push_stamp(rnd | 64'h8000_0000_0000_0000);
            endcase
         end else begin
            if (pick < 20)
               drain_next = 1'b1;
            exponent = $urandom_range(1, 44);
            rnd = rand64();
            base = 64'd1 + (rnd >> (STAMP_W - exponent));
            run_len = $urandom_range(8, 40);
            repeat (run_len) begin
               rnd = rand64();
               pick = $urandom_range(0, 99);
               if (pick < 60)
                  interval = base - (base >> 2) + (rnd % ((base >> 1) + 1));
               else if (pick < 85)
                  interval = base * $urandom_range(2, 6);
               else if (pick < 95)
                  interval = 64'd1 + (rnd % ((base >> 2) + 1));
               else
                  interval = rnd >> $urandom_range(1, 20);
               if (interval == '0)
                  interval = 64'd1;
               push_interval(interval);
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (stamps_accepted < stamps_queued || expected_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_counts.size() != 0) begin
         $error("repeat_count: %0d predicted beats never arrived", expected_counts.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
